// ===== rtl/periodic_task_dispatcher_top_macros.svh =====
// Assertion macros for the periodic task dispatcher.
// Depends on nothing; included by the top level only.
`ifndef PERIODIC_TASK_DISPATCHER_TOP_MACROS_SVH
`define PERIODIC_TASK_DISPATCHER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PTD_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("dispatcher check failed");

// Next-cycle implication, checked outside reset.
`define PTD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("dispatcher check failed");

`endif

// ===== rtl/ptd_pkg.sv =====
// Shared types and constants of the periodic task dispatcher.
// Depends on nothing.
`default_nettype none

package ptd_pkg;

    // Input kinds.
    localparam logic [2:0] K_TICK    = 3'd0;
    localparam logic [2:0] K_CREATE  = 3'd1;
    localparam logic [2:0] K_SUSPEND = 3'd2;
    localparam logic [2:0] K_RESUME  = 3'd3;
    localparam logic [2:0] K_DELETE  = 3'd4;

    // Field widths.
    localparam int KIND_W   = 3;
    localparam int INSLOT_W = 8;
    localparam int PERIOD_W = 16;
    localparam int DUE_W    = 6;

    // At most this many due slots are reported per tick.
    localparam int MAX_RESULTS = 8;
    localparam int FOUND_W     = $clog2(MAX_RESULTS + 1);

    // One slot of the task table as it sits in memory.
    typedef struct packed {
        logic                present;
        logic                resumed;
        logic [PERIOD_W-1:0] period;
    } slot_entry_t;

endpackage

`default_nettype wire

// ===== rtl/periodic_task_dispatcher_top.sv =====
// Periodic task dispatcher: task table in a synchronous memory, tick scan with
// a shared bit-serial remainder unit. Depends on ptd_pkg and the macro header.
//
//  channel   handshake               payload
//  --------  ----------------------  ---------------------------------------
//  input     start & !busy           kind, task_slot, period, code_present
//  result    result_valid (1 cycle)  due_slot, due_valid, accepted, last
//
// A table operation reads the memory, then writes back; a rejected
// kind or out-of-range slot gives its result the cycle after acceptance.
// A tick reads each slot from memory once, and runs each present, resumed,
// nonzero-period slot through the one-bit-per-cycle remainder unit.
// Reset clears the tick counter and the per-entry valid bits; an entry never
// written reads as all zero. The receiver cannot stall; busy holds off start.
`default_nettype none

`include "periodic_task_dispatcher_top_macros.svh"

module periodic_task_dispatcher_top #(
    parameter int TASK_SLOTS = 8
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [ptd_pkg::KIND_W-1:0]     kind,
    input  wire logic [ptd_pkg::INSLOT_W-1:0]   task_slot,
    input  wire logic [ptd_pkg::PERIOD_W-1:0]   period,
    input  wire logic                           code_present,
    output logic                                result_valid,
    output logic [ptd_pkg::DUE_W-1:0]           due_slot,
    output logic                                due_valid,
    output logic                                accepted,
    output logic                                last
);
    import ptd_pkg::*;

    localparam int SLOT_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam logic [SLOT_W-1:0]   LAST_SLOT  = SLOT_W'(TASK_SLOTS - 1);
    localparam logic [INSLOT_W-1:0] SLOT_LIMIT = INSLOT_W'(TASK_SLOTS);
    localparam logic [FOUND_W-1:0]  FOUND_STOP = FOUND_W'(MAX_RESULTS - 1);

    // Sequencer states.
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_OP   = 3'd1;
    localparam logic [2:0] S_CHK  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    // Task table memory and its per-entry valid bits.
    slot_entry_t               mem [TASK_SLOTS];
    logic [TASK_SLOTS-1:0]     vld_reg;
    slot_entry_t               rd_data_reg;
    logic                      rd_vld_reg;

    logic                      rd_en;
    logic [SLOT_W-1:0]         rd_addr;
    logic                      wr_en;
    logic [SLOT_W-1:0]         wr_addr;
    slot_entry_t               wr_data;

    // Control and working registers.
    logic [2:0]                state_reg, state_next;
    logic [PERIOD_W-1:0]       tick_reg, tick_next;
    logic [KIND_W-1:0]         kind_reg, kind_next;
    logic [SLOT_W-1:0]         op_slot_reg, op_slot_next;
    logic [PERIOD_W-1:0]       period_reg, period_next;
    logic                      code_reg, code_next;
    logic [SLOT_W-1:0]         scan_reg, scan_next;
    logic [FOUND_W-1:0]        found_reg, found_next;
    logic                      pend_vld_reg, pend_vld_next;
    logic [SLOT_W-1:0]         pend_slot_reg, pend_slot_next;

    // Remainder unit registers.
    logic [PERIOD_W-1:0]       rem_reg, rem_next;
    logic [PERIOD_W-1:0]       dvd_reg, dvd_next;
    logic [PERIOD_W-1:0]       den_reg, den_next;
    logic [3:0]                cnt_reg, cnt_next;

    // Result registers.
    logic                      res_vld_reg;
    logic [DUE_W-1:0]          res_slot_reg;
    logic                      res_due_reg;
    logic                      res_acc_reg;
    logic                      res_last_reg;

    logic                      emit;
    logic [DUE_W-1:0]          emit_slot;
    logic                      emit_due;
    logic                      emit_acc;
    logic                      emit_last;

    slot_entry_t               entry;
    logic                      slot_active;
    logic                      scan_end;
    logic                      advance;
    logic                      op_ok;
    logic                      in_range;
    logic [PERIOD_W:0]         trial;
    logic [PERIOD_W:0]         diff;
    logic [PERIOD_W-1:0]       rem_step;

    // An entry that was never written reads as the reset value.
    assign entry       = rd_vld_reg ? rd_data_reg : '0;
    assign slot_active = entry.present && entry.resumed && (entry.period != '0);
    assign scan_end    = (scan_reg == LAST_SLOT);
    assign in_range    = (task_slot < SLOT_LIMIT);

    // One restoring step of the remainder: shift in a dividend bit, subtract if it fits.
    assign trial    = {rem_reg, dvd_reg[PERIOD_W-1]};
    assign diff     = trial - {1'b0, den_reg};
    assign rem_step = diff[PERIOD_W] ? trial[PERIOD_W-1:0] : diff[PERIOD_W-1:0];

    // Sequencer and datapath next-state logic.
    always_comb
    begin
        state_next     = state_reg;
        tick_next      = tick_reg;
        kind_next      = kind_reg;
        op_slot_next   = op_slot_reg;
        period_next    = period_reg;
        code_next      = code_reg;
        scan_next      = scan_reg;
        found_next     = found_reg;
        pend_vld_next  = pend_vld_reg;
        pend_slot_next = pend_slot_reg;
        rem_next       = rem_reg;
        dvd_next       = dvd_reg;
        den_next       = den_reg;
        cnt_next       = cnt_reg;
        rd_en          = 1'b0;
        rd_addr        = scan_reg;
        wr_en          = 1'b0;
        wr_addr        = op_slot_reg;
        wr_data        = entry;
        emit           = 1'b0;
        emit_slot      = '0;
        emit_due       = 1'b0;
        emit_acc       = 1'b0;
        emit_last      = 1'b1;
        advance        = 1'b0;
        op_ok          = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    kind_next    = kind;
                    op_slot_next = task_slot[SLOT_W-1:0];
                    period_next  = period;
                    code_next    = code_present;
                    if (kind == K_TICK)
                    begin
                        tick_next     = tick_reg + 1'b1;
                        scan_next     = '0;
                        found_next    = '0;
                        pend_vld_next = 1'b0;
                        rd_en         = 1'b1;
                        rd_addr       = '0;
                        state_next    = S_CHK;
                    end
                    else if (in_range &&
                             (kind inside {K_CREATE, K_SUSPEND, K_RESUME, K_DELETE}))
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = task_slot[SLOT_W-1:0];
                        state_next = S_OP;
                    end
                    else
                    begin
                        // Unknown kind or slot out of range: reject at once.
                        emit = 1'b1;
                    end
                end
            end

            S_OP:
            begin
                // Read-modify-write of the addressed slot.
                case (kind_reg)
                    K_CREATE:
                    begin
                        if (code_reg && !entry.present)
                        begin
                            wr_data.present = 1'b1;
                            wr_data.resumed = 1'b1;
                            wr_data.period  = period_reg;
                            op_ok           = 1'b1;
                        end
                    end
                    K_SUSPEND:
                    begin
                        wr_data.resumed = 1'b0;
                        op_ok           = 1'b1;
                    end
                    K_RESUME:
                    begin
                        wr_data.resumed = 1'b1;
                        op_ok           = 1'b1;
                    end
                    K_DELETE:
                    begin
                        wr_data.present = 1'b0;
                        op_ok           = 1'b1;
                    end
                    default:
                    begin
                        op_ok = 1'b0;
                    end
                endcase
                wr_en      = op_ok;
                emit       = 1'b1;
                emit_acc   = op_ok;
                state_next = S_IDLE;
            end

            S_CHK:
            begin
                if (slot_active)
                begin
                    rem_next   = '0;
                    dvd_next   = tick_reg;
                    den_next   = entry.period;
                    cnt_next   = 4'd15;
                    state_next = S_DIV;
                end
                else
                begin
                    advance = 1'b1;
                end
            end

            S_DIV:
            begin
                rem_next = rem_step;
                dvd_next = {dvd_reg[PERIOD_W-2:0], 1'b0};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == 4'd0)
                begin
                    if (rem_step == '0)
                    begin
                        // A due slot: release the one held back, hold this one.
                        if (pend_vld_reg)
                        begin
                            emit      = 1'b1;
                            emit_slot = DUE_W'(pend_slot_reg);
                            emit_due  = 1'b1;
                            emit_last = 1'b0;
                        end
                        pend_vld_next  = 1'b1;
                        pend_slot_next = scan_reg;
                        found_next     = found_reg + 1'b1;
                        if (found_reg == FOUND_STOP)
                        begin
                            state_next = S_FIN;
                        end
                        else
                        begin
                            advance = 1'b1;
                        end
                    end
                    else
                    begin
                        advance = 1'b1;
                    end
                end
            end

            S_FIN:
            begin
                // Final result of the tick: the held slot, or a none result.
                emit = 1'b1;
                if (pend_vld_reg)
                begin
                    emit_slot = DUE_W'(pend_slot_reg);
                    emit_due  = 1'b1;
                end
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Move the scan to the next slot, or finish after the last one.
        if (advance)
        begin
            if (scan_end)
            begin
                state_next = S_FIN;
            end
            else
            begin
                scan_next  = scan_reg + 1'b1;
                rd_en      = 1'b1;
                rd_addr    = scan_reg + 1'b1;
                state_next = S_CHK;
            end
        end
    end

    // Task table memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Valid bits of the table and of the read data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            tick_reg     <= '0;
            found_reg    <= '0;
            pend_vld_reg <= 1'b0;
            res_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            tick_reg     <= tick_next;
            found_reg    <= found_next;
            pend_vld_reg <= pend_vld_next;
            res_vld_reg  <= emit;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        kind_reg      <= kind_next;
        op_slot_reg   <= op_slot_next;
        period_reg    <= period_next;
        code_reg      <= code_next;
        scan_reg      <= scan_next;
        pend_slot_reg <= pend_slot_next;
        rem_reg       <= rem_next;
        dvd_reg       <= dvd_next;
        den_reg       <= den_next;
        cnt_reg       <= cnt_next;
        if (emit)
        begin
            res_slot_reg <= emit_slot;
            res_due_reg  <= emit_due;
            res_acc_reg  <= emit_acc;
            res_last_reg <= emit_last;
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = res_vld_reg;
    assign due_slot     = res_slot_reg;
    assign due_valid    = res_due_reg;
    assign accepted     = res_acc_reg;
    assign last         = res_last_reg;

    // Checks on the sequencer.
    `PTD_ASSERT_NEXT(a_accept_progress, clk, rst_n, start && !busy, busy || result_valid)
    `PTD_ASSERT_NOW(a_mid_result_busy, clk, rst_n, result_valid && !last, busy && due_valid)
    `PTD_ASSERT_NOW(a_accept_alone, clk, rst_n, result_valid && accepted, last && !due_valid)
    `PTD_ASSERT_NOW(a_found_bound, clk, rst_n, 1'b1, found_reg <= FOUND_W'(MAX_RESULTS))

endmodule

`default_nettype wire

// ===== dv/ptd_dispatch_checker.sv =====
// Checker for the periodic task dispatcher: predicts every result of each accepted
// transaction and compares it with what the block emits. Depends on ptd_pkg.
module ptd_dispatch_checker #(
    parameter int TASK_SLOTS = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic                         busy,
    input  logic [ptd_pkg::KIND_W-1:0]   kind,
    input  logic [ptd_pkg::INSLOT_W-1:0] task_slot,
    input  logic [ptd_pkg::PERIOD_W-1:0] period,
    input  logic                         code_present,
    input  logic                         result_valid,
    input  logic [ptd_pkg::DUE_W-1:0]    due_slot,
    input  logic                         due_valid,
    input  logic                         accepted,
    input  logic                         last,
    output int                           fail_count,
    output int                           pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import ptd_pkg::*;

    typedef struct packed {
        logic [DUE_W-1:0] due_slot;
        logic             due_valid;
        logic             accepted;
        logic             last;
    } dispatch_result_t;

    // Shadow copy of the task table and the tick counter.
    logic [PERIOD_W-1:0]   tick_ctr;
    logic [TASK_SLOTS-1:0] slot_present;
    logic [TASK_SLOTS-1:0] slot_resumed;
    logic [PERIOD_W-1:0]   slot_period [TASK_SLOTS];

    dispatch_result_t awaited_dispatches [$];
    int mismatches;

    // Update the shadow table for one transaction and queue the results it causes.
    task automatic predict_dispatch(
        input logic [KIND_W-1:0]   k,
        input logic [INSLOT_W-1:0] s,
        input logic [PERIOD_W-1:0] p,
        input logic                code
    );
        int due_list [MAX_RESULTS];
        int n_due;
        logic ok;
        begin
            n_due = 0;
            ok = 1'b0;
            if (k == K_TICK)
            begin
                tick_ctr = tick_ctr + 1'b1;
                // Collect the lowest-numbered due slots, up to the report limit.
                for (int i = 0; i < TASK_SLOTS; i++)
                begin
                    if (n_due < MAX_RESULTS && slot_present[i] && slot_resumed[i] &&
                        slot_period[i] != '0 && (tick_ctr % slot_period[i]) == '0)
                    begin
                        due_list[n_due] = i;
                        n_due++;
                    end
                end
                if (n_due == 0)
                    awaited_dispatches.push_back('{due_slot: '0, due_valid: 1'b0,
                                                   accepted: 1'b0, last: 1'b1});
                for (int j = 0; j < n_due; j++)
                    awaited_dispatches.push_back('{due_slot: DUE_W'(due_list[j]),
                                                   due_valid: 1'b1, accepted: 1'b0,
                                                   last: (j == n_due - 1)});
            end
            else
            begin
                // Table operations; anything out of range or of unknown kind is rejected.
                if (s < TASK_SLOTS)
                begin
                    case (k)
                        K_CREATE:
                        begin
                            if (code && !slot_present[s])
                            begin
                                slot_period[s] = p;
                                slot_present[s] = 1'b1;
                                slot_resumed[s] = 1'b1;
                                ok = 1'b1;
                            end
                        end
                        K_SUSPEND:
                        begin
                            slot_resumed[s] = 1'b0;
                            ok = 1'b1;
                        end
                        K_RESUME:
                        begin
                            slot_resumed[s] = 1'b1;
                            ok = 1'b1;
                        end
                        K_DELETE:
                        begin
                            slot_present[s] = 1'b0;
                            ok = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                awaited_dispatches.push_back('{due_slot: '0, due_valid: 1'b0,
                                               accepted: ok, last: 1'b1});
            end
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Compare results first, since a result never belongs to a transaction
    // accepted at the same edge; then predict the new transaction.
    always @(posedge clk or negedge rst_n)
    begin
        dispatch_result_t want;
        if (!rst_n)
        begin
            tick_ctr = '0;
            slot_present = '0;
            slot_resumed = '0;
            for (int i = 0; i < TASK_SLOTS; i++)
                slot_period[i] = '0;
            awaited_dispatches.delete();
            mismatches = 0;
            pending <= 0;
            fail_count <= 0;
        end
        else
        begin
            if (result_valid)
            begin
                if (awaited_dispatches.size() == 0)
                begin
                    $error("unexpected result: due_slot %0d due_valid %0b accepted %0b last %0b",
                           due_slot, due_valid, accepted, last);
                    mismatches++;
                end
                else
                begin
                    want = awaited_dispatches.pop_front();
                    check_field("due_slot", 8'(want.due_slot), 8'(due_slot));
                    check_field("due_valid", 8'(want.due_valid), 8'(due_valid));
                    check_field("accepted", 8'(want.accepted), 8'(accepted));
                    check_field("last", 8'(want.last), 8'(last));
                end
            end
            if (start && !busy)
                predict_dispatch(kind, task_slot, period, code_present);
            pending <= awaited_dispatches.size();
            fail_count <= mismatches;
        end
    end

endmodule

// ===== dv/testbench.sv =====
// Top of the dispatcher testbench: clock, reset, directed and random transactions.
// Depends on ptd_pkg, periodic_task_dispatcher_top and ptd_dispatch_checker.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ptd_pkg::*;

    localparam int TASK_SLOTS      = 8;
    localparam int ITEMS_PER_PHASE = 150;
    localparam int SETTLE_CYCLES   = 200;
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam logic [KIND_W-1:0] KIND_MAX = '1;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [KIND_W-1:0]   kind;
    logic [INSLOT_W-1:0] task_slot;
    logic [PERIOD_W-1:0] period;
    logic                code_present;
    logic                result_valid;
    logic [DUE_W-1:0]    due_slot;
    logic                due_valid;
    logic                accepted;
    logic                last;

    int fail_count;
    int pending;
    int sender_idle_pct;
    int quiet_cycles;

    periodic_task_dispatcher_top #(
        .TASK_SLOTS(TASK_SLOTS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .kind(kind),
        .task_slot(task_slot),
        .period(period),
        .code_present(code_present),
        .result_valid(result_valid),
        .due_slot(due_slot),
        .due_valid(due_valid),
        .accepted(accepted),
        .last(last)
    );

    ptd_dispatch_checker #(
        .TASK_SLOTS(TASK_SLOTS)
    ) dispatch_check (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .kind(kind),
        .task_slot(task_slot),
        .period(period),
        .code_present(code_present),
        .result_valid(result_valid),
        .due_slot(due_slot),
        .due_valid(due_valid),
        .accepted(accepted),
        .last(last),
        .fail_count(fail_count),
        .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Count cycles in which neither a transaction nor a result is accepted.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((start && !busy) || result_valid)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : watchdog
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("testbench failed");
        $finish;
    end

    // Present one transaction, idling first at the current rate, and hold it
    // until the block takes it.
    task automatic send_op(
        input logic [KIND_W-1:0]   k,
        input logic [INSLOT_W-1:0] s,
        input logic [PERIOD_W-1:0] p,
        input logic                code
    );
        while ($urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        kind <= k;
        task_slot <= s;
        period <= p;
        code_present <= code;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Stop sending until every predicted result has come back.
    task automatic drain_results();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    initial
    begin
        logic [KIND_W-1:0]   k;
        logic [INSLOT_W-1:0] s;
        logic [PERIOD_W-1:0] p;
        logic                c;
        int                  r;

        rst_n <= 1'b0;
        start <= 1'b0;
        kind <= K_TICK;
        task_slot <= '0;
        period <= '0;
        code_present <= 1'b0;
        sender_idle_pct = 11;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty tick, create rejects, period zero, suspend and resume.
        send_op(K_TICK, 8'd0, 16'd0, 1'b0);
        send_op(K_CREATE, 8'd0, 16'd1, 1'b1);
        send_op(K_CREATE, 8'd0, 16'd5, 1'b1);
        send_op(K_CREATE, 8'd1, 16'd1, 1'b0);
        send_op(K_CREATE, 8'd8, 16'd1, 1'b1);
        send_op(K_CREATE, 8'd1, 16'd0, 1'b1);
        send_op(K_CREATE, 8'd7, 16'hFFFF, 1'b1);
        send_op(K_TICK, 8'd0, 16'd0, 1'b0);
        send_op(K_SUSPEND, 8'd0, 16'd0, 1'b0);
        send_op(K_TICK, 8'd0, 16'd0, 1'b0);
        send_op(K_RESUME, 8'd0, 16'd0, 1'b0);

        // Delete keeps resumed; resume on an empty slot is still accepted.
        send_op(K_DELETE, 8'd0, 16'd0, 1'b0);
        send_op(K_RESUME, 8'd0, 16'd0, 1'b0);
        send_op(K_CREATE, 8'd0, 16'd2, 1'b1);
        for (int i = 2; i < TASK_SLOTS - 1; i++)
            send_op(K_CREATE, 8'(i), 16'd1, 1'b1);
        send_op(K_TICK, 8'd0, 16'd0, 1'b0);
        drain_results();

        // Recreate slots 1 and 7 with period one so an even tick reports the maximum count.
        send_op(K_DELETE, 8'd1, 16'd0, 1'b0);
        send_op(K_CREATE, 8'd1, 16'd1, 1'b1);
        send_op(K_DELETE, 8'd7, 16'd0, 1'b0);
        send_op(K_CREATE, 8'd7, 16'd1, 1'b1);
        send_op(K_TICK, 8'd0, 16'd0, 1'b0);
        send_op(K_TICK, 8'd0, 16'd0, 1'b0);

        // Unknown kinds and out-of-range slots are rejected.
        send_op(K_DELETE + 3'd1, 8'd0, 16'd0, 1'b1);
        send_op(KIND_MAX, 8'd3, 16'd0, 1'b1);
        send_op(K_SUSPEND, 8'd200, 16'd0, 1'b0);
        send_op(K_DELETE, 8'd255, 16'd0, 1'b0);
        drain_results();

        // Random phases: moderate sender idling, heavy idling, then none.
        for (int ph = 0; ph < 3; ph++)
        begin
            sender_idle_pct = (ph == 0) ? 11 : (ph == 1) ? 73 : 0;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                r = $urandom_range(99);
                k = K_TICK;
                s = INSLOT_W'($urandom_range(TASK_SLOTS - 1));
                p = PERIOD_W'($urandom_range(12, 1));
                c = 1'b1;
                if (r < 40)
                    k = K_TICK;
                else if (r < 60)
                begin
                    k = K_CREATE;
                    case ($urandom_range(9))
                        0: p = '0;
                        1, 2: p = PERIOD_W'($urandom_range(16'hFFFF));
                        default: c = ($urandom_range(15) != 0);
                    endcase
                end
                else if (r < 70)
                    k = K_SUSPEND;
                else if (r < 80)
                    k = K_RESUME;
                else if (r < 90)
                    k = K_DELETE;
                else
                begin
                    // Noise: any kind, any slot, any period, any code bit.
                    k = KIND_W'($urandom_range(KIND_MAX));
                    s = INSLOT_W'($urandom_range(8'hFF));
                    p = PERIOD_W'($urandom_range(16'hFFFF));
                    c = 1'($urandom_range(1));
                end
                send_op(k, s, p, c);
            end
            drain_results();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/ptd_pkg.sv
rtl/periodic_task_dispatcher_top.sv
dv/ptd_dispatch_checker.sv
dv/testbench.sv
